>>> rtl/olt_pkg.sv
// shared types and constants for the ordered list table
`default_nettype none

package olt_pkg;

  // default number of list entries
  localparam int OLT_CAPACITY = 128;
  // width of one list entry
  localparam int OLT_DATA_W = 32;
  // cells per group in the first-match encoder
  localparam int OLT_GROUP = 16;

  // request kinds as carried on in_tuser
  typedef enum logic [1:0] {
    OLT_INSERT = 2'd0,
    OLT_DELETE = 2'd1,
    OLT_UPDATE = 2'd2,
    OLT_SEARCH = 2'd3
  } olt_kind_t;

  // operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_UPD
  } olt_cell_op_t;

  // control broadcast to the row of cells
  typedef struct packed {
    olt_cell_op_t                  op;
    logic signed [OLT_DATA_W-1:0]  value;
  } olt_cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/olt_cell.sv
// one list cell: holds an entry, shifts with its neighbors, compares for search
`default_nettype none

module olt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 8
) (
  input  wire                                   clk,
  input  wire olt_pkg::olt_cell_ctl_t           ctl_i,
  input  wire logic [CNT_W-1:0]                 sel_i,
  input  wire logic [CNT_W-1:0]                 count_i,
  input  wire logic signed [olt_pkg::OLT_DATA_W-1:0] left_i,
  input  wire logic signed [olt_pkg::OLT_DATA_W-1:0] right_i,
  output logic signed [olt_pkg::OLT_DATA_W-1:0] entry_o,
  output logic                                  match_o
);
  import olt_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic signed [OLT_DATA_W-1:0] entry_r;
  logic signed [OLT_DATA_W-1:0] entry_nxt;
  logic                         match_r;
  logic                         match_nxt;

  // next entry from the broadcast operation
  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl_i.op)
      CELL_INS: begin
        if (MY_IDX == sel_i) begin
          entry_nxt = ctl_i.value;
        end else if (MY_IDX > sel_i) begin
          entry_nxt = left_i;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= sel_i) begin
          entry_nxt = right_i;
        end
      end
      CELL_UPD: begin
        if (MY_IDX == sel_i) begin
          entry_nxt = ctl_i.value;
        end
      end
      CELL_HOLD: begin
        entry_nxt = entry_r;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // match only counts inside the live part of the list
  assign match_nxt = (entry_r == ctl_i.value) && (MY_IDX < count_i);

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry_o = entry_r;
  assign match_o = match_r;

endmodule

`default_nettype wire

>>> rtl/olt_first.sv
// two-stage first-match encoder over the cell match bits
`default_nettype none

module olt_first #(
  parameter int N     = 128,
  parameter int G     = 16,
  parameter int NG    = (N + G - 1) / G,
  parameter int GI_W  = (NG > 1) ? $clog2(NG) : 1,
  parameter int OFF_W = $clog2(G)
) (
  input  wire                         clk,
  input  wire logic [N-1:0]           match_i,
  output logic                        hit_o,
  output logic [GI_W+OFF_W-1:0]       index_o
);

  logic [NG*G-1:0]  padded;
  logic [NG-1:0]    any;
  logic [OFF_W-1:0] off   [NG];
  logic [NG-1:0]    any_r;
  logic [OFF_W-1:0] off_r [NG];
  logic [GI_W-1:0]  gsel;

  assign padded = (NG*G)'(match_i);

  // stage one: per-group hit and lowest offset inside the group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      any[g] = |padded[g*G +: G];
      off[g] = '0;
      for (int k = G - 1; k >= 0; k--) begin
        if (padded[g*G + k]) begin
          off[g] = OFF_W'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    any_r <= any;
    off_r <= off;
  end

  // stage two: lowest group that holds a hit
  always_comb begin
    gsel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (any_r[g]) begin
        gsel = GI_W'(g);
      end
    end
  end

  assign hit_o   = |any_r;
  assign index_o = {gsel, off_r[gsel]};

endmodule

`default_nettype wire

>>> rtl/ordered_list_table_core.sv
// ordered list table top level: request control, row of cells, result register
`default_nettype none

// Bounded ordered list of signed 32-bit words kept in a row of cells, one entry
// per cell, with the current length held beside it. Each request word on the
// in_ channel carries an operation (insert, delete, update, search), a 1-based
// position and a value; each yields exactly one result word with a fail flag,
// the position of the first match for a successful search, and the list length
// after the operation. One request is in flight at a time. Insert, delete and
// update pass through the accept cycle and an execute cycle in which the
// whole row shifts or writes in place and the result register is loaded.
// Search passes through accept, an execute cycle in which the cells compare in
// parallel into registered match bits, then a two-stage first-match encoder
// (16 cells per group, then across groups, group results registered between)
// finds the lowest position. The result sits in an output register, so a new
// request is taken once the previous result has been loaded there, even if it
// has not yet been read; a result still waiting there holds the next request
// in its execute cycle (or last scan cycle for search) until it is taken.

module ordered_list_table_core #(
  parameter int CAPACITY = olt_pkg::OLT_CAPACITY
) (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: position[7:0], value[39:8]
  input  wire  [39:0] in_tdata,
  // in_tuser: kind[1:0]
  input  wire  [1:0]  in_tuser,
  input  wire         in_tvalid,
  output logic        in_tready,
  // out_tdata: found_position[7:0], list_length[15:8]
  output logic [15:0] out_tdata,
  // out_tuser: failed[0]
  output logic [0:0]  out_tuser,
  output logic        out_tvalid,
  input  wire         out_tready
);
  import olt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam int NG    = (CAPACITY + OLT_GROUP - 1) / OLT_GROUP;
  localparam int GI_W  = (NG > 1) ? $clog2(NG) : 1;
  localparam int OFF_W = $clog2(OLT_GROUP);
  localparam int IX_W  = GI_W + OFF_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN1,
    S_SCAN2
  } state_t;

  state_t                       state_r,   state_nxt;
  logic [CNT_W-1:0]             count_r,   count_nxt;
  olt_kind_t                    kind_r,    kind_nxt;
  logic [7:0]                   pos_r,     pos_nxt;
  logic signed [OLT_DATA_W-1:0] value_r,   value_nxt;
  logic                         ovalid_r,  ovalid_nxt;
  logic                         ofail_r,   ofail_nxt;
  logic [7:0]                   ofound_r,  ofound_nxt;
  logic [7:0]                   olen_r,    olen_nxt;

  logic                         slot_free;
  logic [CMP_W-1:0]             pos_w;
  logic [CMP_W-1:0]             cnt_w;
  logic                         ins_ok;
  logic                         pos_ok;
  logic                         req_ok;
  logic [CNT_W-1:0]             sel;
  olt_cell_ctl_t                ctl;
  logic signed [OLT_DATA_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]          match;
  logic                         hit;
  logic [IX_W-1:0]              hit_idx;
  logic [IX_W:0]                hit_pos;

  // request checks against the current length
  assign slot_free = !ovalid_r || out_tready;
  assign pos_w     = CMP_W'(pos_r);
  assign cnt_w     = CMP_W'(count_r);
  assign ins_ok    = (pos_r != 8'd0) && (pos_w <= cnt_w + CMP_W'(1))
                     && (cnt_w < CMP_W'(CAPACITY));
  assign pos_ok    = (pos_r != 8'd0) && (pos_w <= cnt_w);
  assign req_ok    = (kind_r == OLT_INSERT) ? ins_ok : pos_ok;
  assign sel       = CNT_W'(pos_w - CMP_W'(1));

  // broadcast to the row: only in the execute cycle with room for the result
  always_comb begin
    ctl.value = value_r;
    ctl.op    = CELL_HOLD;
    if (state_r == S_EXEC && slot_free && req_ok) begin
      unique case (kind_r)
        OLT_INSERT: ctl.op = CELL_INS;
        OLT_DELETE: ctl.op = CELL_DEL;
        OLT_UPDATE: ctl.op = CELL_UPD;
        OLT_SEARCH: ctl.op = CELL_HOLD;
        default:    ctl.op = CELL_HOLD;
      endcase
    end
  end

  // row of cells, each shifting with its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [OLT_DATA_W-1:0] left;
    logic signed [OLT_DATA_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entry[i+1];
    end
    olt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .sel_i   (sel),
      .count_i (count_r),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[i]),
      .match_o (match[i])
    );
  end

  // first match over the registered compare bits
  olt_first #(
    .N (CAPACITY),
    .G (OLT_GROUP)
  ) u_first (
    .clk     (clk),
    .match_i (match),
    .hit_o   (hit),
    .index_o (hit_idx)
  );

  assign hit_pos = {1'b0, hit_idx} + (IX_W+1)'(1);

  // sequencer and result register
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    value_nxt  = value_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ofail_nxt  = ofail_r;
    ofound_nxt = ofound_r;
    olen_nxt   = olen_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = olt_kind_t'(in_tuser);
          pos_nxt   = in_tdata[7:0];
          value_nxt = in_tdata[39:8];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (kind_r == OLT_SEARCH) begin
          state_nxt = S_SCAN1;
        end else if (slot_free) begin
          if (req_ok && kind_r == OLT_INSERT) begin
            count_nxt = count_r + CNT_W'(1);
          end else if (req_ok && kind_r == OLT_DELETE) begin
            count_nxt = count_r - CNT_W'(1);
          end
          ovalid_nxt = 1'b1;
          ofail_nxt  = !req_ok;
          ofound_nxt = 8'd0;
          olen_nxt   = 8'(count_nxt);
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN1: begin
        state_nxt = S_SCAN2;
      end
      S_SCAN2: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ofail_nxt  = !hit;
          ofound_nxt = hit ? 8'(hit_pos) : 8'd0;
          olen_nxt   = 8'(count_r);
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
    kind_r   <= kind_nxt;
    pos_r    <= pos_nxt;
    value_r  <= value_nxt;
    ofail_r  <= ofail_nxt;
    ofound_r <= ofound_nxt;
    olen_r   <= olen_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {olen_r, ofound_r};
  assign out_tuser  = ofail_r;

endmodule

`default_nettype wire

>>> rtl/olt_checker.sv
// port-level checks for the ordered list table, bound to the top level
`default_nettype none

module olt_checker #(
  parameter int CAPACITY = 128
) (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [15:0] out_tdata,
  input wire [0:0]  out_tuser,
  input wire        out_tvalid,
  input wire        out_tready
);

  // a result word waiting to be taken holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // a failed result never reports a position
  a_fail_nopos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[7:0] == 8'd0)
    else $error("failed result carries a position");

  // a found position lies inside the list
  a_pos_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:0] != 8'd0 |->
      (CAPACITY > 255) || (out_tdata[7:0] <= out_tdata[15:8]))
    else $error("found position past list length");

  // one request in flight: no word taken in the cycle after one was taken
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in flight");

endmodule

bind ordered_list_table_core olt_checker #(
  .CAPACITY (CAPACITY)
) u_olt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
